### design/lst_pkg.sv
// Shared types, constants and keyword tables for the layout spec tokenizer.
`timescale 1ns / 1ps

package lst_pkg;

  // Offset counter width; offsets and lengths leave the block as 16-bit fields.
  localparam int OFFSET_BITS = 16;
  localparam int FIELD_BITS  = 16;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [FIELD_BITS-1:0]  field_t;

  localparam offset_t POS_MAX  = '1;
  localparam field_t  LINE_MAX = '1;
  localparam field_t  LINE_ONE = field_t'(1);

  // Token kinds as they appear on the output.
  typedef enum logic [3:0] {
    KIND_EOL,
    KIND_X,
    KIND_Y,
    KIND_DELIM,
    KIND_NUMBER,
    KIND_LAYER,
    KIND_WIDTH,
    KIND_NAME,
    KIND_HEIGHT,
    KIND_POWER,
    KIND_STRING,
    KIND_EOF
  } kind_t;

  typedef struct packed {
    kind_t  kind;
    field_t start;
    field_t len;
    field_t line;
  } token_t;

  // One input item gives at most three tokens; they travel together.
  localparam int RUN_MAX    = 3;
  localparam int COUNT_BITS = $clog2(RUN_MAX + 1);
  localparam int SUB_BITS   = $clog2(RUN_MAX);

  typedef struct packed {
    logic [COUNT_BITS-1:0]  count;
    token_t [RUN_MAX-1:0]   tok;
  } bundle_t;

  // Queue between scanner and output serializer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_EQ    = "=";

  // Keywords, zero padded; order matches KIND_LAYER onward.
  localparam int NUM_KW = 5;
  localparam logic [7:0] KW_CHARS [NUM_KW][8] = '{
    '{"l", "a", "y", "e", "r", 8'h00, 8'h00, 8'h00},
    '{"w", "i", "d", "t", "h", 8'h00, 8'h00, 8'h00},
    '{"n", "a", "m", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"h", "e", "i", "g", "h", "t", 8'h00, 8'h00},
    '{"p", "o", "w", "e", "r", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd5, 3'd4, 3'd6, 3'd5};

endpackage

### design/lst_front.sv
// Scanner front end: accepts characters, tracks the pending token and builds token bundles.
`timescale 1ns / 1ps

module lst_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       ch,
  input  logic             char_valid,
  input  logic             end_of_source,
  output logic             push,
  output lst_pkg::bundle_t push_bundle,
  input  logic             queue_full
);
  import lst_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC
  } mode_t;

  mode_t              mode, mode_next;
  offset_t            position, position_next;
  offset_t            token_start, token_start_next;
  offset_t            number_end, number_end_next;
  field_t             line_count, line_count_next;
  logic [NUM_KW-1:0]  kw_match, kw_match_next;
  logic [2:0]         ident_len, ident_len_next;

  logic               accept;
  logic               fresh;
  offset_t            pos_inc;
  logic               is_dig;
  logic               is_alp;
  token_t             cand [RUN_MAX];
  logic [RUN_MAX-1:0] cand_en;
  logic [COUNT_BITS-1:0] n_tok;

  function automatic logic [NUM_KW-1:0] kw_step(logic [NUM_KW-1:0] m, logic [2:0] len,
                                                 logic [7:0] c);
    logic [NUM_KW-1:0] r;
    r = m;
    for (int i = 0; i < NUM_KW; i++) begin
      if (len >= KW_LEN[i] || KW_CHARS[i][len] != c) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic kind_t ident_kind(logic [NUM_KW-1:0] m, logic [2:0] len);
    kind_t k;
    k = KIND_STRING;
    // Walk downward so the first matching keyword wins.
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (m[i] && len == KW_LEN[i]) begin
        k = kind_t'(KIND_LAYER + 4'(i));
      end
    end
    return k;
  endfunction

  function automatic token_t make_tok(kind_t k, offset_t s, offset_t l, field_t ln);
    token_t t;
    t.kind  = k;
    t.start = FIELD_BITS'(s);
    t.len   = FIELD_BITS'(l);
    t.line  = ln;
    return t;
  endfunction

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign pos_inc  = (position != POS_MAX) ? position + 1'b1 : position;
  assign is_dig   = (ch >= "0") && (ch <= "9");
  assign is_alp   = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));

  // Next scanner state and the candidate tokens: flush, then fresh or end flush, then EOF.
  always_comb begin
    mode_next        = mode;
    position_next    = position;
    token_start_next = token_start;
    number_end_next  = number_end;
    line_count_next  = line_count;
    kw_match_next    = kw_match;
    ident_len_next   = ident_len;
    fresh            = 1'b0;
    cand_en          = '0;
    for (int i = 0; i < RUN_MAX; i++) begin
      cand[i] = '0;
    end

    if (char_valid) begin
      position_next = pos_inc;
      case (mode)
        MODE_IDENT: begin
          if (is_alp || is_dig) begin
            kw_match_next  = kw_step(kw_match, ident_len, ch);
            ident_len_next = (ident_len != 3'd7) ? ident_len + 3'd1 : ident_len;
          end else begin
            cand_en[0] = 1'b1;
            cand[0]    = make_tok(ident_kind(kw_match, ident_len), token_start,
                                  position - token_start, line_count);
            fresh      = 1'b1;
          end
        end
        MODE_INT: begin
          if (ch == CH_DOT) begin
            mode_next       = MODE_DOT;
            number_end_next = position;
          end else if (!is_dig) begin
            cand_en[0] = 1'b1;
            cand[0]    = make_tok(KIND_NUMBER, token_start, position - token_start,
                                  line_count);
            fresh      = 1'b1;
          end
        end
        MODE_DOT: begin
          if (is_dig) begin
            mode_next = MODE_FRAC;
          end else begin
            // The dot did not start a fraction: the number ends before it.
            cand_en[0] = 1'b1;
            cand[0]    = make_tok(KIND_NUMBER, token_start, number_end - token_start,
                                  line_count);
            fresh      = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (!is_dig) begin
            cand_en[0] = 1'b1;
            cand[0]    = make_tok(KIND_NUMBER, token_start, position - token_start,
                                  line_count);
            fresh      = 1'b1;
          end
        end
        default: begin
          fresh = 1'b1;
        end
      endcase

      // Scan the character on its own from the idle state.
      if (fresh) begin
        mode_next      = MODE_IDLE;
        kw_match_next  = '1;
        ident_len_next = 3'd0;
        if (ch == CH_NL) begin
          cand_en[1] = 1'b1;
          cand[1]    = make_tok(KIND_EOL, position, offset_t'(1), line_count);
          if (line_count != LINE_MAX) begin
            line_count_next = line_count + 1'b1;
          end
        end else if (ch == "x" || ch == "X") begin
          cand_en[1] = 1'b1;
          cand[1]    = make_tok(KIND_X, position, offset_t'(1), line_count);
        end else if (ch == "y" || ch == "Y") begin
          cand_en[1] = 1'b1;
          cand[1]    = make_tok(KIND_Y, position, offset_t'(1), line_count);
        end else if (ch == CH_COLON || ch == CH_EQ || ch == CH_SEMI || ch == CH_COMMA) begin
          cand_en[1] = 1'b1;
          cand[1]    = make_tok(KIND_DELIM, position, offset_t'(1), line_count);
        end else if (is_dig) begin
          mode_next        = MODE_INT;
          token_start_next = position;
        end else if (is_alp) begin
          mode_next        = MODE_IDENT;
          token_start_next = position;
          kw_match_next    = kw_step('1, 3'd0, ch);
          ident_len_next   = 3'd1;
        end
      end
    end

    // End of source: flush what is pending, give EOF, return to the reset state.
    if (end_of_source) begin
      case (mode_next)
        MODE_IDENT: begin
          cand_en[1] = 1'b1;
          cand[1]    = make_tok(ident_kind(kw_match_next, ident_len_next), token_start_next,
                                position_next - token_start_next, line_count_next);
        end
        MODE_INT, MODE_FRAC: begin
          cand_en[1] = 1'b1;
          cand[1]    = make_tok(KIND_NUMBER, token_start_next,
                                position_next - token_start_next, line_count_next);
        end
        MODE_DOT: begin
          cand_en[1] = 1'b1;
          cand[1]    = make_tok(KIND_NUMBER, token_start_next,
                                number_end_next - token_start_next, line_count_next);
        end
        default: begin
        end
      endcase
      cand_en[2]       = 1'b1;
      cand[2]          = make_tok(KIND_EOF, position_next, offset_t'(0), line_count_next);
      mode_next        = MODE_IDLE;
      position_next    = '0;
      token_start_next = '0;
      number_end_next  = '0;
      line_count_next  = LINE_ONE;
      kw_match_next    = '1;
      ident_len_next   = 3'd0;
    end
  end

  // Pack the enabled candidates in order into one bundle.
  always_comb begin
    push_bundle = '0;
    n_tok       = '0;
    for (int i = 0; i < RUN_MAX; i++) begin
      if (cand_en[i]) begin
        push_bundle.tok[SUB_BITS'(n_tok)] = cand[i];
        n_tok = n_tok + 1'b1;
      end
    end
    push_bundle.count = n_tok;
  end

  assign push = accept && (n_tok != '0);

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      position    <= '0;
      token_start <= '0;
      number_end  <= '0;
      line_count  <= LINE_ONE;
      kw_match    <= '1;
      ident_len   <= 3'd0;
    end else if (accept) begin
      mode        <= mode_next;
      position    <= position_next;
      token_start <= token_start_next;
      number_end  <= number_end_next;
      line_count  <= line_count_next;
      kw_match    <= kw_match_next;
      ident_len   <= ident_len_next;
    end
  end

endmodule

### design/lst_queue.sv
// Short bundle queue between the scanner and the output serializer.
`timescale 1ns / 1ps

module lst_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lst_pkg::bundle_t push_bundle,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output lst_pkg::bundle_t head_bundle
);
  import lst_pkg::*;

  bundle_t              entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] cnt;

  assign full        = (cnt == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid  = (cnt != '0);
  assign head_bundle = entries[rd_ptr];

  // Entry storage; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // A push never lands on a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  // The fill count follows a lone push.
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 1'b1)
    else $error("fill count did not follow push");

endmodule

### design/lst_back.sv
// Output serializer: hands out the tokens of the head bundle one beat at a time.
`timescale 1ns / 1ps

module lst_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  lst_pkg::bundle_t head_bundle,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       token_kind,
  output logic [15:0]      start_offset,
  output logic [15:0]      token_length,
  output logic [15:0]      line_number,
  output logic             last_of_run
);
  import lst_pkg::*;

  logic [SUB_BITS-1:0] sub;
  logic                fire;
  token_t              cur;

  assign out_valid    = head_valid;
  assign cur          = head_bundle.tok[sub];
  assign token_kind   = cur.kind;
  assign start_offset = cur.start;
  assign token_length = cur.len;
  assign line_number  = cur.line;
  assign last_of_run  = (COUNT_BITS'(sub) == head_bundle.count - 1'b1);
  assign fire         = out_valid && !out_stall;
  assign pop          = fire && last_of_run;

  // Token index within the head bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= '0;
    end else if (fire) begin
      sub <= last_of_run ? '0 : sub + 1'b1;
    end
  end

  // The queue only holds bundles that carry tokens.
  assert property (@(posedge clk) disable iff (rst) head_valid |-> head_bundle.count != '0)
    else $error("empty bundle at queue head");

  // The token index stays inside the head bundle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> COUNT_BITS'(sub) < head_bundle.count)
    else $error("token index past bundle end");

endmodule

### design/layout_spec_tokenizer.sv
// Top level of the layout spec tokenizer: scanner, bundle queue and output serializer.
`timescale 1ns / 1ps

// Usage
// The input channel takes one beat per source byte: ch with char_valid, and
// end_of_source to close the source after that beat. A beat with char_valid low
// and end_of_source low does nothing. in_stall holds off the sender.
// The output channel gives one token per beat: kind, start offset, length, line,
// and last_of_run on the final token caused by one input beat.
// Each input beat is scanned in the cycle it is accepted and gives zero to three
// tokens; any that it gives are written as one entry into a four-entry queue.
// They are offered from the queue head, one per cycle while out_stall is low.
// Sustained rate is one input beat per cycle while tokens drain at least as fast;
// the output serializer, one token per unstalled cycle, sets the limit on bursts.
// When out_stall is high the current token holds and the queue fills; once it
// is full in_stall rises until a bundle has been sent.
// Reset empties the queue and returns the scanner to the start of a source,
// line one, offset zero. End of source returns the scanner there after its EOF token.

module layout_spec_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        char_valid,
  input  logic        end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [15:0] start_offset,
  output logic [15:0] token_length,
  output logic [15:0] line_number,
  output logic        last_of_run
);
  import lst_pkg::*;

  logic    push;
  bundle_t push_bundle;
  logic    queue_full;
  logic    pop;
  logic    head_valid;
  bundle_t head_bundle;

  lst_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ch            (ch),
    .char_valid    (char_valid),
    .end_of_source (end_of_source),
    .push          (push),
    .push_bundle   (push_bundle),
    .queue_full    (queue_full)
  );

  lst_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (queue_full),
    .pop         (pop),
    .head_valid  (head_valid),
    .head_bundle (head_bundle)
  );

  lst_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_bundle  (head_bundle),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .line_number  (line_number),
    .last_of_run  (last_of_run)
  );

endmodule

### tb/layout_spec_tokenizer_tb.sv
// Self-checking testbench for the layout spec tokenizer: directed table, random sources, scoreboard.
`timescale 1ns / 1ps

module layout_spec_tokenizer_tb;
  import lst_pkg::*;

  localparam int IDLE_LIMIT       = 2000;
  localparam int SETTLE_CYCLES    = 20;
  localparam int NUM_DIRECTED     = 24;
  localparam int RANDOM_PER_PHASE = 50;
  localparam int MAX_REPORTS      = 10;

  // Scanner modes of the predictor.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_INT,
    SCAN_DOT,
    SCAN_FRAC
  } scan_mode_t;

  typedef struct packed {
    token_t tok;
    logic   last;
  } token_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       eos;
    logic       typed;
    token_t     tok;
  } stim_row_t;

  localparam token_t NO_TOK = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  ch = 8'h00;
  logic        char_valid = 1'b0;
  logic        end_of_source = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic        last_of_run;

  // Predictor state.
  scan_mode_t  sc_mode;
  int unsigned sc_pos;
  int unsigned sc_start;
  int unsigned sc_line;
  int unsigned sc_numend;
  logic [4:0]  sc_kw;
  logic [2:0]  sc_idlen;

  token_beat_t beat_tokens[$];
  token_beat_t expected_tokens[$];
  token_beat_t want_tok;
  logic [7:0]  lexeme_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches = 0;
  int tokens_checked = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;

  // Directed rows; only tokens that are obvious at a glance are typed in.
  stim_row_t stim_rows [NUM_DIRECTED] = '{
    '{CH_COLON, 1'b1, 1'b0, 1'b1, '{KIND_DELIM, 16'd0, 16'd1, 16'd1}},
    '{CH_NL,    1'b1, 1'b0, 1'b1, '{KIND_EOL, 16'd1, 16'd1, 16'd1}},
    '{"X",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{"y",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{8'h00,    1'b1, 1'b0, 1'b0, NO_TOK},
    '{8'hFF,    1'b1, 1'b0, 1'b0, NO_TOK},
    '{8'h09,    1'b1, 1'b0, 1'b0, NO_TOK},
    '{"9",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_DOT,   1'b1, 1'b0, 1'b0, NO_TOK},
    '{"a",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{"0",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{" ",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{"1",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_DOT,   1'b1, 1'b0, 1'b0, NO_TOK},
    '{"5",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_EQ,    1'b1, 1'b0, 1'b0, NO_TOK},
    '{"7",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_DOT,   1'b1, 1'b1, 1'b0, NO_TOK},
    '{8'h5A,    1'b0, 1'b0, 1'b0, NO_TOK},
    '{8'hA5,    1'b0, 1'b1, 1'b1, '{KIND_EOF, 16'd0, 16'd0, 16'd1}},
    '{"q",      1'b1, 1'b0, 1'b0, NO_TOK},
    '{CH_SEMI,  1'b1, 1'b1, 1'b0, NO_TOK},
    '{CH_COMMA, 1'b1, 1'b0, 1'b1, '{KIND_DELIM, 16'd0, 16'd1, 16'd1}},
    '{8'h7E,    1'b0, 1'b1, 1'b1, '{KIND_EOF, 16'd1, 16'd0, 16'd1}}
  };

  layout_spec_tokenizer u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ch            (ch),
    .char_valid    (char_valid),
    .end_of_source (end_of_source),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_kind    (token_kind),
    .start_offset  (start_offset),
    .token_length  (token_length),
    .line_number   (line_number),
    .last_of_run   (last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Append one character to the pending source text.
  function automatic void queue_char(logic [7:0] c);
    lexeme_q.insert(lexeme_q.size(), c);
  endfunction

  function automatic void add_token(kind_t k, int unsigned s, int unsigned l);
    token_beat_t t;
    t.tok.kind  = k;
    t.tok.start = field_t'(s);
    t.tok.len   = field_t'(l);
    t.tok.line  = field_t'(sc_line);
    t.last      = 1'b0;
    beat_tokens.insert(beat_tokens.size(), t);
  endfunction

  function automatic void clear_ident();
    sc_mode  = SCAN_IDLE;
    sc_kw    = '1;
    sc_idlen = '0;
  endfunction

  function automatic void restart_source();
    clear_ident();
    sc_pos    = 0;
    sc_start  = 0;
    sc_line   = 1;
    sc_numend = 0;
  endfunction

  // Drop every keyword that the new identifier character rules out.
  function automatic void match_keyword_char(logic [7:0] c);
    for (int i = 0; i < NUM_KW; i++) begin
      if (sc_idlen >= KW_LEN[i] || KW_CHARS[i][sc_idlen] != c) begin
        sc_kw[i] = 1'b0;
      end
    end
    if (sc_idlen < 3'd7) begin
      sc_idlen = sc_idlen + 3'd1;
    end
  endfunction

  // Emit the pending number or identifier, if any.
  function automatic void flush_token();
    kind_t k;
    bit    found;
    k     = KIND_STRING;
    found = 1'b0;
    case (sc_mode)
      SCAN_IDENT: begin
        for (int i = 0; i < NUM_KW; i++) begin
          if (!found && sc_kw[i] && sc_idlen == KW_LEN[i]) begin
            k     = kind_t'(KIND_LAYER + i);
            found = 1'b1;
          end
        end
        add_token(k, sc_start, sc_pos - sc_start);
      end
      SCAN_INT, SCAN_FRAC: add_token(KIND_NUMBER, sc_start, sc_pos - sc_start);
      SCAN_DOT: add_token(KIND_NUMBER, sc_start, sc_numend - sc_start);
      default: ;
    endcase
    clear_ident();
  endfunction

  // Scan a character with no token pending.
  function automatic void scan_char(logic [7:0] c, int unsigned p);
    if (c == CH_NL) begin
      add_token(KIND_EOL, p, 1);
      if (sc_line < LINE_MAX) begin
        sc_line++;
      end
    end else if (c == "x" || c == "X") begin
      add_token(KIND_X, p, 1);
    end else if (c == "y" || c == "Y") begin
      add_token(KIND_Y, p, 1);
    end else if (c == CH_COLON || c == CH_EQ || c == CH_SEMI || c == CH_COMMA) begin
      add_token(KIND_DELIM, p, 1);
    end else if (is_digit(c)) begin
      sc_mode  = SCAN_INT;
      sc_start = p;
    end else if (is_alpha(c)) begin
      clear_ident();
      sc_mode  = SCAN_IDENT;
      sc_start = p;
      match_keyword_char(c);
    end
  endfunction

  // Close the pending token just before this character, then scan the character.
  function automatic void end_and_rescan(logic [7:0] c, int unsigned p);
    sc_pos = p;
    flush_token();
    if (p < POS_MAX) begin
      sc_pos = p + 1;
    end
    scan_char(c, p);
  endfunction

  // Work out the tokens that one input beat causes.
  function automatic void predict_tokens(logic [7:0] c, logic cv, logic eos);
    int unsigned p;
    beat_tokens.delete();
    if (cv) begin
      p = sc_pos;
      if (sc_pos < POS_MAX) begin
        sc_pos++;
      end
      case (sc_mode)
        SCAN_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            match_keyword_char(c);
          end else begin
            end_and_rescan(c, p);
          end
        end
        SCAN_INT: begin
          if (c == CH_DOT) begin
            sc_mode   = SCAN_DOT;
            sc_numend = p;
          end else if (!is_digit(c)) begin
            end_and_rescan(c, p);
          end
        end
        SCAN_DOT: begin
          if (is_digit(c)) begin
            sc_mode = SCAN_FRAC;
          end else begin
            flush_token();
            scan_char(c, p);
          end
        end
        SCAN_FRAC: begin
          if (!is_digit(c)) begin
            end_and_rescan(c, p);
          end
        end
        default: scan_char(c, p);
      endcase
    end
    if (eos) begin
      flush_token();
      add_token(KIND_EOF, sc_pos, 0);
      restart_source();
    end
    if (beat_tokens.size() > 0) begin
      beat_tokens[beat_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  // Append one lexeme of source text, well formed most of the time.
  function automatic void add_lexeme();
    int k;
    int n;
    int v;
    case ($urandom_range(0, 11))
      0, 1: begin
        k = $urandom_range(0, NUM_KW - 1);
        v = $urandom_range(0, 5);
        n = (v == 2) ? KW_LEN[k] - 1 : KW_LEN[k];
        for (int j = 0; j < n; j++) begin
          queue_char((v == 0 && j == 0) ? KW_CHARS[k][j] ^ 8'h20 : KW_CHARS[k][j]);
        end
        if (v == 1) begin
          queue_char(8'("0" + $urandom_range(0, 9)));
        end
      end
      2: begin
        n = $urandom_range(1, 8);
        queue_char(rand_letter());
        for (int j = 1; j < n; j++) begin
          queue_char($urandom_range(0, 2) == 0 ? 8'("0" + $urandom_range(0, 9))
                                               : rand_letter());
        end
      end
      3: begin
        n = $urandom_range(1, 5);
        for (int j = 0; j < n; j++) begin
          queue_char(8'("0" + $urandom_range(0, 9)));
        end
        v = $urandom_range(0, 7);
        if (v < 4) begin
          queue_char(CH_DOT);
          n = $urandom_range(1, 3);
          for (int j = 0; j < n; j++) begin
            queue_char(8'("0" + $urandom_range(0, 9)));
          end
        end else if (v == 4) begin
          queue_char(CH_DOT);
        end
      end
      4: begin
        case ($urandom_range(0, 3))
          0: queue_char("x");
          1: queue_char("X");
          2: queue_char("y");
          default: queue_char("Y");
        endcase
      end
      5: begin
        case ($urandom_range(0, 3))
          0: queue_char(CH_COLON);
          1: queue_char(CH_EQ);
          2: queue_char(CH_SEMI);
          default: queue_char(CH_COMMA);
        endcase
      end
      6: queue_char(CH_NL);
      7: queue_char(8'h09);
      9: queue_char(8'($urandom_range(0, 255)));
      default: queue_char(" ");
    endcase
  endfunction

  // Drive one beat after a random gap and hold it until it is taken.
  task automatic send_beat(input logic [7:0] c, input logic cv, input logic eos,
                           input logic typed = 1'b0, input token_t typed_tok = '0);
    token_beat_t t;
    predict_tokens(c, cv, eos);
    if (typed) begin
      t.tok  = typed_tok;
      t.last = 1'b1;
      beat_tokens.delete();
      beat_tokens.insert(0, t);
    end
    foreach (beat_tokens[i]) begin
      expected_tokens.insert(expected_tokens.size(), beat_tokens[i]);
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    ch            <= c;
    char_valid    <= cv;
    end_of_source <= eos;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    beats_sent++;
  endtask

  // Random source text, with stray end markers and empty beats mixed in.
  task automatic run_random(input int n_items);
    int sent;
    int roll;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else if (roll < 5) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        sent++;
      end else begin
        if (lexeme_q.size() == 0) begin
          add_lexeme();
        end
        send_beat(lexeme_q.pop_front(), 1'b1, $urandom_range(0, 39) == 0);
        sent++;
      end
    end
    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Hold the sender off until every predicted token has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_tokens.size() != 0);
  endtask

  // Output side: random stall, compare each token beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected token: kind %0d start %0d len %0d line %0d last %0b",
                   token_kind, start_offset, token_length, line_number, last_of_run);
        end
      end else begin
        want_tok = expected_tokens.pop_front();
        if (token_kind !== want_tok.tok.kind || start_offset !== want_tok.tok.start ||
            token_length !== want_tok.tok.len || line_number !== want_tok.tok.line ||
            last_of_run !== want_tok.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("token %0d: expected kind %0d start %0d len %0d line %0d last %0b",
                     tokens_checked, want_tok.tok.kind, want_tok.tok.start,
                     want_tok.tok.len, want_tok.tok.line, want_tok.last);
            $display("          got      kind %0d start %0d len %0d line %0d last %0b",
                     token_kind, start_offset, token_length, line_number, last_of_run);
          end
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("** layout_spec_tokenizer: FAILED **");
      $finish;
    end
  end

  // Main sequence: directed table, then three stall profiles of random sources.
  initial begin
    restart_source();
    send_idle_pct = 34;
    recv_idle_pct = 51;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      send_beat(stim_rows[i].ch, stim_rows[i].cv, stim_rows[i].eos,
                stim_rows[i].typed, stim_rows[i].tok);
    end
    run_random(RANDOM_PER_PHASE);
    wait_drained();

    send_idle_pct = 51;
    recv_idle_pct = 34;
    run_random(RANDOM_PER_PHASE);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d source beats and checked %0d tokens under three stall profiles,",
             beats_sent, tokens_checked);
    $display("including broken fractions, keywords, stray bytes and bare end markers.");
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("** layout_spec_tokenizer: PASSED **");
    end else begin
      $display("** layout_spec_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule

### layout_spec_tokenizer.f
design/lst_pkg.sv
design/lst_front.sv
design/lst_queue.sv
design/lst_back.sv
design/layout_spec_tokenizer.sv
tb/layout_spec_tokenizer_tb.sv
